// ----- hw/rtl/imucal_pkg.sv -----
package imucal_pkg;

  // Default width of the sample counters.
  localparam int COUNT_WIDTH_DEF = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_GYRO_GAIN    = 2'd1,
    CFG_ACCEL_GAIN   = 2'd2
  } cfg_reg_t;

  // Field and datapath widths.
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 24;
  localparam int AXIS_W   = 16;
  localparam int SUM_W    = 32;
  localparam int PROD_W   = SUM_W + GAIN_W;
  localparam int FRAC_DROP = 8;
  localparam int DIVD_W   = PROD_W - FRAC_DROP;
  localparam int RES_W    = 32;
  localparam int GOOD_W   = 16;

  // Axis order in the accumulator bank: accel x, y, z, then gyro x, y, z.
  localparam int NUM_AXES   = 6;
  localparam int NUM_ACCEL  = 3;
  localparam int AXIS_IDX_W = 3;

  // The divider retires one quotient bit per cycle.
  localparam int DIV_STEPS = DIVD_W;
  localparam int STEP_W    = 6;

  localparam logic [SAMPLE_W-1:0] SAMPLE_COUNT_RST = 16'd256;
  localparam logic [GAIN_W-1:0]   GYRO_GAIN_RST    = 24'd256140;
  localparam logic [GAIN_W-1:0]   ACCEL_GAIN_RST   = 24'd10042;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accum;
    logic err_load;
    logic calc_start;
    logic mul;
    logic div_step;
    logic store;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic error;
    logic out_busy;
    logic div_done;
    logic axis_last;
  } dp_stat_t;

  // Applies the sign to a truncated quotient magnitude and clamps it to the
  // signed 32-bit range.
  function automatic logic [RES_W-1:0] sat_signed(input logic neg,
                                                  input logic [DIVD_W-1:0] q);
    logic [RES_W-1:0] mag;
    logic [RES_W-1:0] res;
    if (neg) begin
      if (q > DIVD_W'(33'h080000000)) begin
        mag = 32'h80000000;
      end else begin
        mag = q[RES_W-1:0];
      end
      res = 32'd0 - mag;
    end else begin
      if (q[DIVD_W-1:RES_W-1] != '0) begin
        res = 32'h7FFFFFFF;
      end else begin
        res = q[RES_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/imu_calibration_averager_core.sv -----
// After the last sample of a run, an error result is loaded when too few samples were good;
// otherwise each axis in turn passes through a multiply, the divide steps and a store.
// Throughput: one sample transaction per cycle during a run; input stalls while the six scaled
// means are computed by the shared bit-serial divider, and at run end while a result waits.
// Reset (synchronous, active high): idle with no run open, counters and sums cleared,
// configuration registers at their defaults (256 samples, gains 256140 and 10042).
module imu_calibration_averager_core #(
  parameter int COUNT_WIDTH = imucal_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [imucal_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [imucal_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic                                 sample_good,
  input  logic signed [imucal_pkg::AXIS_W-1:0] accel_x,
  input  logic signed [imucal_pkg::AXIS_W-1:0] accel_y,
  input  logic signed [imucal_pkg::AXIS_W-1:0] accel_z,
  input  logic signed [imucal_pkg::AXIS_W-1:0] rate_x,
  input  logic signed [imucal_pkg::AXIS_W-1:0] rate_y,
  input  logic signed [imucal_pkg::AXIS_W-1:0] rate_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 status,
  output logic [imucal_pkg::GOOD_W-1:0]        good_count,
  output logic signed [imucal_pkg::RES_W-1:0]  bias_x,
  output logic signed [imucal_pkg::RES_W-1:0]  bias_y,
  output logic signed [imucal_pkg::RES_W-1:0]  bias_z,
  output logic signed [imucal_pkg::RES_W-1:0]  ref_x,
  output logic signed [imucal_pkg::RES_W-1:0]  ref_y,
  output logic signed [imucal_pkg::RES_W-1:0]  ref_z
);
  import imucal_pkg::*;

  // The controller sequences the run: it opens a run on a start transaction,
  // hands samples to the accumulators, and at the end of the run either
  // loads an error result or walks the six axes through the scaling unit.
  // The datapath holds the configuration, the sums and counters, the
  // multiplier, the shared restoring divider and the result registers.
  // A finished result sits in the output registers until it is taken, so
  // the next run can already collect samples; only its completion waits.

  dp_cmd_t  dp_cmd;
  dp_stat_t stat;

  imucal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .dp_cmd   (dp_cmd)
  );

  // Each mean is sum * gain / (good * 256): the product keeps 24 fraction
  // bits, the low 8 are dropped before the divide, which gives the same
  // truncated quotient, and the sign is applied with saturation afterwards.
  imucal_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_good (sample_good),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .rate_x      (rate_x),
    .rate_y      (rate_y),
    .rate_z      (rate_z),
    .dp_cmd      (dp_cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .good_count  (good_count),
    .bias_x      (bias_x),
    .bias_y      (bias_y),
    .bias_z      (bias_z),
    .ref_x       (ref_x),
    .ref_y       (ref_y),
    .ref_z       (ref_z)
  );

endmodule

// ----- hw/rtl/imucal_ctrl.sv -----
module imucal_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 cmd,
  output logic                 in_ready,
  input  imucal_pkg::dp_stat_t stat,
  output imucal_pkg::dp_cmd_t  dp_cmd
);
  import imucal_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RUN   = 6'b000010,
    ST_WAIT  = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_STORE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE) || (state == ST_RUN);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    case (state)
      ST_IDLE: begin
        if (accept && !cmd) begin
          dp_cmd.clear = 1'b1;
          state_next   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept) begin
          if (!cmd) begin
            dp_cmd.clear = 1'b1;
          end else begin
            dp_cmd.accum = 1'b1;
            if (stat.last) begin
              state_next = ST_WAIT;
            end
          end
        end
      end
      ST_WAIT: begin
        if (!stat.out_busy) begin
          if (stat.error) begin
            dp_cmd.err_load = 1'b1;
            state_next      = ST_IDLE;
          end else begin
            dp_cmd.calc_start = 1'b1;
            state_next        = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        dp_cmd.mul = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        dp_cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        dp_cmd.store = 1'b1;
        if (stat.axis_last) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MUL;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/imucal_dp.sv -----
module imucal_dp #(
  parameter int COUNT_WIDTH = imucal_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [imucal_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [imucal_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                 sample_good,
  input  logic signed [imucal_pkg::AXIS_W-1:0] accel_x,
  input  logic signed [imucal_pkg::AXIS_W-1:0] accel_y,
  input  logic signed [imucal_pkg::AXIS_W-1:0] accel_z,
  input  logic signed [imucal_pkg::AXIS_W-1:0] rate_x,
  input  logic signed [imucal_pkg::AXIS_W-1:0] rate_y,
  input  logic signed [imucal_pkg::AXIS_W-1:0] rate_z,
  input  imucal_pkg::dp_cmd_t                  dp_cmd,
  output imucal_pkg::dp_stat_t                 stat,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 status,
  output logic [imucal_pkg::GOOD_W-1:0]        good_count,
  output logic signed [imucal_pkg::RES_W-1:0]  bias_x,
  output logic signed [imucal_pkg::RES_W-1:0]  bias_y,
  output logic signed [imucal_pkg::RES_W-1:0]  bias_z,
  output logic signed [imucal_pkg::RES_W-1:0]  ref_x,
  output logic signed [imucal_pkg::RES_W-1:0]  ref_y,
  output logic signed [imucal_pkg::RES_W-1:0]  ref_z
);
  import imucal_pkg::*;

  localparam logic [SAMPLE_W-1:0] CMAX16 =
    SAMPLE_W'((32'd1 << COUNT_WIDTH) - 32'd1);

  // Configuration registers.
  logic [SAMPLE_W-1:0] sample_count;
  logic [GAIN_W-1:0]   gyro_gain;
  logic [GAIN_W-1:0]   accel_gain;

  // Run state.
  logic [SUM_W-1:0]       sums [NUM_AXES];
  logic [COUNT_WIDTH-1:0] samples_seen;
  logic [COUNT_WIDTH-1:0] samples_good;

  // Scaling unit.
  logic [AXIS_IDX_W-1:0]  axis;
  logic [COUNT_WIDTH-1:0] rem;
  logic [DIVD_W-1:0]      dq;
  logic [STEP_W-1:0]      step_cnt;
  logic                   neg;

  // Result registers.
  logic [RES_W-1:0] res [NUM_AXES];

  logic signed [AXIS_W-1:0] axis_in [NUM_AXES];
  logic [COUNT_WIDTH-1:0]   count_eff;
  logic [COUNT_WIDTH-1:0]   seen_inc;
  logic [SUM_W-1:0]         sum_sel;
  logic [SUM_W-1:0]         mag;
  logic [GAIN_W-1:0]        gain_sel;
  logic [PROD_W-1:0]        prod;
  logic [COUNT_WIDTH:0]     shifted;
  logic [COUNT_WIDTH:0]     diff;
  logic                     q_bit;

  assign axis_in[0] = accel_x;
  assign axis_in[1] = accel_y;
  assign axis_in[2] = accel_z;
  assign axis_in[3] = rate_x;
  assign axis_in[4] = rate_y;
  assign axis_in[5] = rate_z;

  // Effective run length: zero means one, and it cannot pass the counter range.
  always_comb begin
    if (sample_count == '0) begin
      count_eff = COUNT_WIDTH'(1);
    end else if (sample_count > CMAX16) begin
      count_eff = CMAX16[COUNT_WIDTH-1:0];
    end else begin
      count_eff = sample_count[COUNT_WIDTH-1:0];
    end
  end

  assign seen_inc = samples_seen + COUNT_WIDTH'(1);

  assign stat.last      = seen_inc >= count_eff;
  assign stat.error     = (samples_good == '0) || (samples_good < (count_eff >> 1));
  assign stat.out_busy  = out_valid;
  assign stat.div_done  = step_cnt == STEP_W'(DIV_STEPS - 1);
  assign stat.axis_last = axis == AXIS_IDX_W'(NUM_AXES - 1);

  // Magnitude times gain for the selected axis.
  assign sum_sel  = sums[axis];
  assign mag      = sum_sel[SUM_W-1] ? (SUM_W'(0) - sum_sel) : sum_sel;
  assign gain_sel = (axis < AXIS_IDX_W'(NUM_ACCEL)) ? accel_gain : gyro_gain;
  assign prod     = PROD_W'(mag) * PROD_W'(gain_sel);

  // One restoring division step.
  assign shifted = {rem, dq[DIVD_W-1]};
  assign q_bit   = shifted >= {1'b0, samples_good};
  assign diff    = shifted - {1'b0, samples_good};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SAMPLE_COUNT_RST;
      gyro_gain    <= GYRO_GAIN_RST;
      accel_gain   <= ACCEL_GAIN_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count <= cfg_data[SAMPLE_W-1:0];
        CFG_GYRO_GAIN:    gyro_gain    <= cfg_data[GAIN_W-1:0];
        CFG_ACCEL_GAIN:   accel_gain   <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
      samples_good <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sums[i] <= '0;
      end
    end else if (dp_cmd.clear) begin
      samples_seen <= '0;
      samples_good <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sums[i] <= '0;
      end
    end else if (dp_cmd.accum) begin
      samples_seen <= seen_inc;
      if (sample_good) begin
        samples_good <= samples_good + COUNT_WIDTH'(1);
        for (int i = 0; i < NUM_AXES; i++) begin
          sums[i] <= sums[i] + SUM_W'(axis_in[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis     <= '0;
      step_cnt <= '0;
    end else begin
      if (dp_cmd.calc_start) begin
        axis <= '0;
      end else if (dp_cmd.store && !stat.axis_last) begin
        axis <= axis + AXIS_IDX_W'(1);
      end
      if (dp_cmd.mul) begin
        step_cnt <= '0;
      end else if (dp_cmd.div_step) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.mul) begin
      dq  <= prod[PROD_W-1:FRAC_DROP];
      rem <= '0;
      neg <= sum_sel[SUM_W-1];
    end else if (dp_cmd.div_step) begin
      dq  <= {dq[DIVD_W-2:0], q_bit};
      rem <= q_bit ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.err_load || (dp_cmd.store && stat.axis_last)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.err_load) begin
      status     <= 1'b1;
      good_count <= GOOD_W'(samples_good);
      for (int i = 0; i < NUM_AXES; i++) begin
        res[i] <= '0;
      end
    end else if (dp_cmd.store) begin
      res[axis] <= sat_signed(neg, dq);
      if (stat.axis_last) begin
        status     <= 1'b0;
        good_count <= GOOD_W'(samples_good);
      end
    end
  end

  assign ref_x  = res[0];
  assign ref_y  = res[1];
  assign ref_z  = res[2];
  assign bias_x = res[3];
  assign bias_y = res[4];
  assign bias_z = res[5];

`ifndef SYNTHESIS
  a_div_not_while_out: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.div_step |-> !out_valid)
    else $error("divider stepping while a result is still held");

  a_good_le_seen: assert property (@(posedge clk) disable iff (rst)
    samples_good <= samples_seen)
    else $error("good sample count exceeds samples seen");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.div_step |-> rem < samples_good)
    else $error("division remainder not below divisor");

  a_out_rise_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(dp_cmd.err_load || (dp_cmd.store && stat.axis_last)))
    else $error("result raised without a completed run");
`endif

endmodule

// ----- tb/imu_calibration_averager_core_tb.sv -----
`timescale 1ns / 100ps

module imu_calibration_averager_core_tb;
  import imucal_pkg::*;

  // Input command codes and result status codes.
  localparam logic CMD_START      = 1'b0;
  localparam logic CMD_SAMPLE     = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TOO_FEW = 1'b1;

  // The index port is two bits wide but only three registers exist, so the
  // last index addresses nothing and a write to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  // Long enough for a run that succeeds to produce its result; this is how long
  // the block is given to fall quiet before its registers change.
  localparam int SETTLE_CYCLES = 320;
  localparam int FINAL_WAIT    = 50000;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int MAX_REPORTS   = 40;
  localparam int HOLDOFF_LEN   = 800;

  localparam logic [AXIS_W-1:0]   AXIS_MAX     = 16'h7FFF;
  localparam logic [AXIS_W-1:0]   AXIS_MIN     = 16'h8000;
  localparam logic [SAMPLE_W-1:0] LONG_RUN_LEN = 16'd48;
  localparam logic [GAIN_W-1:0]   GAIN_MAX     = 24'hFFFFFF;

  // One input transaction: a start command or a six-axis sample.
  typedef struct packed {
    logic                   cmd;
    logic                   good;
    logic [2:0][AXIS_W-1:0] accel;
    logic [2:0][AXIS_W-1:0] rate;
  } imu_sample_t;

  // One calibration result as the block should present it.
  typedef struct packed {
    logic                  status;
    logic [GOOD_W-1:0]     good_count;
    logic [2:0][RES_W-1:0] bias;
    logic [2:0][RES_W-1:0] accel_ref;
  } calib_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    cmd = CMD_START;
  logic                    sample_good = 1'b0;
  logic signed [AXIS_W-1:0] accel_x = '0;
  logic signed [AXIS_W-1:0] accel_y = '0;
  logic signed [AXIS_W-1:0] accel_z = '0;
  logic signed [AXIS_W-1:0] rate_x = '0;
  logic signed [AXIS_W-1:0] rate_y = '0;
  logic signed [AXIS_W-1:0] rate_z = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    status;
  logic [GOOD_W-1:0]       good_count;
  logic signed [RES_W-1:0] bias_x;
  logic signed [RES_W-1:0] bias_y;
  logic signed [RES_W-1:0] bias_z;
  logic signed [RES_W-1:0] ref_x;
  logic signed [RES_W-1:0] ref_y;
  logic signed [RES_W-1:0] ref_z;

  imu_calibration_averager_core u_top (.*);

  // Free-running clock with a 10 ns period.
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Our own copy of the block's configuration and accumulation state. It is
  // advanced at the very edge at which the block accepts each transaction.
  logic [SAMPLE_W-1:0]              n_samples = SAMPLE_COUNT_RST;
  logic [GAIN_W-1:0]                gyro_k = GYRO_GAIN_RST;
  logic [GAIN_W-1:0]                accel_k = ACCEL_GAIN_RST;
  logic [NUM_AXES-1:0][SUM_W-1:0]   cal_sums = '0;
  logic [GOOD_W-1:0]                cal_seen = '0;
  logic [GOOD_W-1:0]                cal_good = '0;
  logic                             cal_open = 1'b0;
  calib_result_t                    calib_expect_q[$];

  // Switches for random idling on each side, and a request for a long
  // hold-off on the result side.
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  int hold_len     = 0;

  int unsigned cycle_n       = 0;
  int          err_n         = 0;
  int          items_sent    = 0;
  int          items_ignored = 0;
  int          results_seen  = 0;
  int          error_results = 0;

  // Hard limit on the length of the run, in case the block stops responding.
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_n,
               calib_expect_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [RES_W-1:0] got,
                                 input logic [RES_W-1:0] want);
    if (err_n < MAX_REPORTS) begin
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    end
    err_n++;
  endtask

  // Mean of one axis in Q15.16: the magnitude of the 32-bit sum times the
  // gain (24 fraction bits) divided by 256 times the number of good samples,
  // truncated, then signed and clamped to 32 bits.
  function automatic logic [RES_W-1:0] scale_to_q16(input logic [SUM_W-1:0] sum,
                                                    input logic [GAIN_W-1:0] gain,
                                                    input logic [GOOD_W-1:0] n);
    logic        neg;
    logic [31:0] mag32;
    logic [63:0] quot;
    neg   = sum[SUM_W-1];
    mag32 = neg ? (32'd0 - sum) : sum;
    quot  = ({32'd0, mag32} * {40'd0, gain}) / ({48'd0, n} << FRAC_DROP);
    if (neg) begin
      if (quot > 64'h80000000) quot = 64'h80000000;
      return 32'd0 - quot[31:0];
    end
    if (quot > 64'h7FFFFFFF) quot = 64'h7FFFFFFF;
    return quot[31:0];
  endfunction

  // Advances the copy of the state by one accepted transaction and queues the
  // result that it completes, if any.
  function automatic void track_sample(input imu_sample_t it);
    logic [SAMPLE_W-1:0] target;
    calib_result_t       r;
    int                  i;
    if (it.cmd == CMD_START) begin
      // A start clears the sums even when it abandons a run in progress.
      cal_sums = '0;
      cal_seen = '0;
      cal_good = '0;
      cal_open = 1'b1;
      return;
    end
    if (!cal_open) return;
    cal_seen = cal_seen + 1'b1;
    if (it.good) begin
      for (i = 0; i < NUM_ACCEL; i++) begin
        cal_sums[i] = cal_sums[i] + {{(SUM_W-AXIS_W){it.accel[i][AXIS_W-1]}}, it.accel[i]};
        cal_sums[NUM_ACCEL+i] = cal_sums[NUM_ACCEL+i]
                              + {{(SUM_W-AXIS_W){it.rate[i][AXIS_W-1]}}, it.rate[i]};
      end
      cal_good = cal_good + 1'b1;
    end
    // A count of zero behaves as one; a count lowered mid-run ends the run at
    // the first sample that reaches or passes it.
    target = (n_samples == '0) ? SAMPLE_W'(1) : n_samples;
    if (cal_seen < target) return;
    cal_open     = 1'b0;
    r            = '0;
    r.good_count = cal_good;
    if (cal_good == '0 || cal_good < (target >> 1)) begin
      r.status = STATUS_TOO_FEW;
    end else begin
      r.status = STATUS_OK;
      for (i = 0; i < NUM_ACCEL; i++) begin
        r.bias[i]      = scale_to_q16(cal_sums[NUM_ACCEL+i], gyro_k, cal_good);
        r.accel_ref[i] = scale_to_q16(cal_sums[i], accel_k, cal_good);
      end
    end
    calib_expect_q.push_back(r);
  endfunction

  // Offers one transaction, possibly after a random idle burst, and waits for
  // the block to take it. Valid is only ever raised or lowered once per edge.
  task automatic send_item(input imu_sample_t it);
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= it.cmd;
    sample_good <= it.good;
    accel_x     <= it.accel[0];
    accel_y     <= it.accel[1];
    accel_z     <= it.accel[2];
    rate_x      <= it.rate[0];
    rate_y      <= it.rate[1];
    rate_z      <= it.rate[2];
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (it.cmd == CMD_SAMPLE && !cal_open) items_ignored++;
    track_sample(it);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Stops offering transactions and waits for every awaited result.
  task automatic wait_results_done();
    go_quiet();
    while (calib_expect_q.size() != 0) @(posedge clk);
  endtask

  // As above, then gives the block time to finish any work that has no
  // result, so that its registers may safely be rewritten.
  task automatic settle_block();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_SAMPLE_COUNT: n_samples = val[SAMPLE_W-1:0];
      CFG_GYRO_GAIN:    gyro_k = val[GAIN_W-1:0];
      CFG_ACCEL_GAIN:   accel_k = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_run_config(input logic [SAMPLE_W-1:0] count,
                                input logic [GAIN_W-1:0] gyro,
                                input logic [GAIN_W-1:0] accel);
    program_register(CFG_SAMPLE_COUNT, CFG_DATA_W'(count));
    program_register(CFG_GYRO_GAIN, gyro);
    program_register(CFG_ACCEL_GAIN, accel);
  endtask

  // Axis value with a bias towards the extremes, so that sums grow large.
  function automatic logic [AXIS_W-1:0] pick_axis();
    case ($urandom_range(0, 9))
      0:       return AXIS_MAX;
      1:       return AXIS_MIN;
      2:       return '0;
      default: return AXIS_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GAIN_MAX;
      default: return GAIN_W'($urandom_range(0, 32'hFFFFFF));
    endcase
  endfunction

  function automatic imu_sample_t random_sample(input logic good);
    imu_sample_t it;
    int          i;
    it.cmd  = CMD_SAMPLE;
    it.good = good;
    for (i = 0; i < 3; i++) begin
      it.accel[i] = pick_axis();
      it.rate[i]  = pick_axis();
    end
    return it;
  endfunction

  // A start command; its other fields carry random noise that must not matter.
  function automatic imu_sample_t start_item();
    imu_sample_t it;
    it     = random_sample(1'($urandom_range(0, 1)));
    it.cmd = CMD_START;
    return it;
  endfunction

  function automatic imu_sample_t fixed_sample(input logic good,
                                               input logic [AXIS_W-1:0] a,
                                               input logic [AXIS_W-1:0] g);
    imu_sample_t it;
    it.cmd   = CMD_SAMPLE;
    it.good  = good;
    it.accel = {3{a}};
    it.rate  = {3{g}};
    return it;
  endfunction

  // Result side: random stalls, plus a long hold-off when one is requested.
  // The hold-off is counted here so that the sender can keep pushing.
  initial begin : result_sink
    int stall_n;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        stall_n  = hold_len;
        hold_len = 0;
        out_ready <= 1'b0;
        repeat (stall_n) @(negedge clk);
        out_ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_result();
    calib_result_t want;
    results_seen++;
    if (calib_expect_q.size() == 0) begin
      report_mismatch("result with none awaited", {31'd0, status}, '0);
      return;
    end
    want = calib_expect_q.pop_front();
    if (want.status == STATUS_TOO_FEW) error_results++;
    if (status !== want.status) report_mismatch("status", {31'd0, status}, {31'd0, want.status});
    if (good_count !== want.good_count) begin
      report_mismatch("good_count", {16'd0, good_count}, {16'd0, want.good_count});
    end
    if (bias_x !== want.bias[0]) report_mismatch("bias_x", bias_x, want.bias[0]);
    if (bias_y !== want.bias[1]) report_mismatch("bias_y", bias_y, want.bias[1]);
    if (bias_z !== want.bias[2]) report_mismatch("bias_z", bias_z, want.bias[2]);
    if (ref_x !== want.accel_ref[0]) report_mismatch("ref_x", ref_x, want.accel_ref[0]);
    if (ref_y !== want.accel_ref[1]) report_mismatch("ref_y", ref_y, want.accel_ref[1]);
    if (ref_z !== want.accel_ref[2]) report_mismatch("ref_z", ref_z, want.accel_ref[2]);
  endtask

  // Every result transaction is compared, field by field, with the oldest
  // result still awaited.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
  end

  // Samples that arrive with no run open are dropped without a result.
  task automatic test_idle_samples();
    send_item(random_sample(1'b1));
    send_item(random_sample(1'b0));
    settle_block();
  endtask

  // With four samples per run, one good sample is too few and two are just
  // enough. The gains sit at opposite extremes.
  task automatic test_error_threshold();
    set_run_config(16'd4, GAIN_MAX, '0);
    send_item(start_item());
    send_item(fixed_sample(1'b1, AXIS_MAX, AXIS_MIN));
    send_item(fixed_sample(1'b0, AXIS_MIN, AXIS_MAX));
    send_item(fixed_sample(1'b0, AXIS_MAX, AXIS_MAX));
    send_item(fixed_sample(1'b0, AXIS_MIN, AXIS_MIN));
    send_item(start_item());
    send_item(fixed_sample(1'b1, AXIS_MIN, AXIS_MAX));
    send_item(fixed_sample(1'b1, AXIS_MAX, AXIS_MIN));
    send_item(fixed_sample(1'b0, '0, '0));
    send_item(fixed_sample(1'b0, AXIS_MAX, AXIS_MAX));
    settle_block();
  endtask

  // A count of zero acts as one: a single bad sample gives an error with no
  // good samples, a single good one gives a full result.
  task automatic test_zero_count();
    set_run_config('0, '0, GAIN_MAX);
    send_item(start_item());
    send_item(fixed_sample(1'b0, AXIS_MAX, AXIS_MAX));
    send_item(start_item());
    send_item(fixed_sample(1'b1, AXIS_MIN, AXIS_MIN));
    settle_block();
  endtask

  // A second start abandons the open run without a result.
  task automatic test_restart_mid_run();
    set_run_config(16'd3, GYRO_GAIN_RST, ACCEL_GAIN_RST);
    send_item(start_item());
    send_item(fixed_sample(1'b1, AXIS_MAX, AXIS_MAX));
    send_item(start_item());
    send_item(random_sample(1'b1));
    send_item(random_sample(1'b1));
    send_item(random_sample(1'b0));
    settle_block();
  endtask

  // Registers rewritten while a run is open: the count drops below the
  // samples already seen, so the next sample closes the run, and the gains
  // then in force are the ones applied.
  task automatic test_config_mid_run();
    set_run_config(16'd5, GYRO_GAIN_RST, ACCEL_GAIN_RST);
    send_item(start_item());
    send_item(random_sample(1'b1));
    send_item(random_sample(1'b1));
    send_item(random_sample(1'b0));
    settle_block();
    set_run_config(16'd2, pick_gain(), pick_gain());
    send_item(random_sample(1'b1));
    settle_block();
  endtask

  // A write to the unused index must leave all three registers alone.
  task automatic test_unused_index();
    set_run_config(16'd1, GAIN_MAX, GAIN_MAX);
    program_register(CFG_UNUSED, CFG_DATA_W'($urandom));
    send_item(start_item());
    send_item(fixed_sample(1'b1, AXIS_MIN, AXIS_MAX));
    settle_block();
  endtask

  // A longer run with every sample good and at the axis extremes, under
  // full-scale gains, so that the sums and the scaled means grow large.
  task automatic test_long_run();
    int k;
    src_idle_on = 1'b0;
    set_run_config(LONG_RUN_LEN, GAIN_MAX, GAIN_MAX);
    send_item(start_item());
    for (k = 0; k < int'(LONG_RUN_LEN); k++) begin
      send_item(fixed_sample(1'b1, AXIS_MIN, AXIS_MAX));
    end
    settle_block();
    src_idle_on = 1'b1;
  endtask

  // The result side holds off for a long stretch while short runs keep
  // coming, so the block has to stall its input until the result is taken.
  task automatic test_output_holdoff();
    int k;
    int j;
    set_run_config(16'd4, pick_gain(), pick_gain());
    hold_len = HOLDOFF_LEN;
    for (k = 0; k < 6; k++) begin
      send_item(start_item());
      for (j = 0; j < 4; j++) send_item(random_sample($urandom_range(0, 3) != 0));
    end
    settle_block();
  endtask

  // The sender stops once, after the second run, until every awaited result has arrived.
  task automatic test_sender_pause();
    int k;
    int j;
    set_run_config(16'd6, pick_gain(), pick_gain());
    for (k = 0; k < 3; k++) begin
      send_item(start_item());
      for (j = 0; j < 6; j++) send_item(random_sample(1'($urandom_range(0, 1))));
      if (k == 1) wait_results_done();
    end
    settle_block();
  endtask

  // Mostly complete runs with random contents and a random share of good
  // samples; some runs are cut short by a new start, and a few samples are
  // sent with no run open.
  task automatic test_random_runs(input int target, input bit idle_on);
    int               done_n;
    int               run_len;
    int               good_pct;
    int               k;
    int               pick;
    logic [SAMPLE_W-1:0] count;
    src_idle_on  = idle_on;
    sink_idle_on = idle_on;
    case ($urandom_range(0, 9))
      0:       count = '0;
      1:       count = SAMPLE_W'($urandom_range(20, 40));
      default: count = SAMPLE_W'($urandom_range(1, 12));
    endcase
    set_run_config(count, pick_gain(), pick_gain());
    done_n = 0;
    while (done_n < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        if (!cal_open) send_item(random_sample(1'($urandom_range(0, 1))));
      end else begin
        send_item(start_item());
        done_n++;
        run_len = (n_samples == '0) ? 1 : int'(n_samples);
        if (pick < 15) run_len = $urandom_range(0, run_len - 1);
        case ($urandom_range(0, 5))
          0:       good_pct = 0;
          1:       good_pct = 10;
          2:       good_pct = 40;
          3:       good_pct = 55;
          4:       good_pct = 80;
          default: good_pct = 100;
        endcase
        for (k = 0; k < run_len; k++) begin
          send_item(random_sample($urandom_range(0, 99) < good_pct));
          done_n++;
        end
      end
    end
    settle_block();
  endtask

  initial begin : stimulus
    int n;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_samples();
    test_error_threshold();
    test_zero_count();
    test_restart_mid_run();
    test_config_mid_run();
    test_unused_index();
    test_long_run();
    test_output_holdoff();
    test_sender_pause();
    repeat (4) test_random_runs(300, 1'b1);
    // The closing stretch runs at full rate with no idling on either side.
    test_random_runs(150, 1'b0);

    go_quiet();
    n = 0;
    while (calib_expect_q.size() != 0 && n < FINAL_WAIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (calib_expect_q.size() != 0) begin
      report_mismatch("results never delivered", calib_expect_q.size(), '0);
    end

    $display("Covered %0d input transactions (%0d dropped with no run open), %0d results",
             items_sent, items_ignored, results_seen);
    $display("of which %0d too-few-good errors; run lengths 1 to 48, gains 0 to full scale",
             error_results);
    if (err_n == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
